FILE: design/auth_sys_credential_parser_assert.svh
// Assertion macros used by the credential parser checker.
`ifndef AUTH_SYS_CREDENTIAL_PARSER_ASSERT_SVH
`define AUTH_SYS_CREDENTIAL_PARSER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ACP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ACP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/acp_pkg.sv
// Shared types and constants of the system-flavor credential parser.
`timescale 1ns / 1ps

package acp_pkg;

  localparam logic [7:0] NAME_MAX_RST  = 8'd255;
  localparam logic [4:0] GIDS_MAX_RST  = 5'd16;
  localparam int         QUEUE_DEPTH   = 4;

  localparam logic [2:0] REG_NAME_MAX  = 3'd0;
  localparam logic [2:0] REG_GIDS_MAX  = 3'd4;

  typedef enum logic [2:0] {
    PH_STAMP   = 3'd0,
    PH_NAMELEN = 3'd1,
    PH_NAME    = 3'd2,
    PH_UID     = 3'd3,
    PH_GID     = 3'd4,
    PH_GCOUNT  = 3'd5,
    PH_GIDS    = 3'd6,
    PH_END     = 3'd7
  } acp_phase_t;

  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_GID  = 2'd1;
  localparam logic [1:0] KIND_SUM  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_SYS   = 3'd1;
  localparam logic [2:0] ST_NAME_LONG = 3'd2;
  localparam logic [2:0] ST_TOO_MANY  = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  // One queue entry: an optional list result, then an optional summary.
  typedef struct packed {
    logic        has_item;
    logic [1:0]  item_kind;
    logic [31:0] item_value;
    logic [7:0]  item_index;
    logic        has_sum;
    logic [2:0]  status;
    logic [31:0] stamp;
    logic [31:0] uid;
    logic [31:0] gid;
    logic [7:0]  name_len;
    logic [4:0]  gcount;
  } acp_entry_t;

  typedef struct packed {
    logic        full;
    logic        empty;
  } acp_q_stat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] item_value;
    logic [7:0]  item_index;
    logic [2:0]  status;
    logic [31:0] stamp;
    logic [31:0] uid;
    logic [31:0] gid;
    logic [7:0]  name_len;
    logic [4:0]  gcount;
    logic        run_end;
  } acp_res_t;

endpackage

FILE: design/acp_if.sv
// Byte request and result channel interfaces of the credential parser.
`timescale 1ns / 1ps

interface acp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       has_data;
  logic       first_byte;
  logic       last_byte;
  logic       sys_flavor;

  modport source (output valid, body_byte, has_data, first_byte, last_byte, sys_flavor,
                  input ready);
  modport sink   (input valid, body_byte, has_data, first_byte, last_byte, sys_flavor,
                  output ready);
endinterface

interface acp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] item_value;
  logic [7:0]  item_index;
  logic [2:0]  status;
  logic [31:0] stamp_out;
  logic [31:0] uid_out;
  logic [31:0] gid_out;
  logic [7:0]  name_length_out;
  logic [4:0]  group_count_out;
  logic        run_end;

  modport source (output valid, kind, item_value, item_index, status, stamp_out, uid_out,
                  gid_out, name_length_out, group_count_out, run_end,
                  input ready);
  modport sink   (input valid, kind, item_value, item_index, status, stamp_out, uid_out,
                  gid_out, name_length_out, group_count_out, run_end,
                  output ready);
endinterface

FILE: design/acp_front.sv
// Front end: field parser that classifies each byte and builds queue entries.
`timescale 1ns / 1ps

module acp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         body_byte,
  input  logic               has_data,
  input  logic               first_byte,
  input  logic               last_byte,
  input  logic               sys_flavor,
  input  logic [7:0]         max_name,
  input  logic [4:0]         max_gids,
  output logic               push,
  output acp_pkg::acp_entry_t entry
);

  acp_pkg::acp_phase_t phase_r, phase_nxt;
  logic [1:0]  biw_r, biw_nxt;
  logic [23:0] wshift_r, wshift_nxt;
  logic [7:0]  name_len_r, name_len_nxt;
  logic [8:0]  brem_r, brem_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [31:0] uid_r, uid_nxt;
  logic [31:0] gid_r, gid_nxt;
  logic [4:0]  gcount_r, gcount_nxt;
  logic [4:0]  gidx_r, gidx_nxt;
  logic [2:0]  status_r, status_nxt;

  // Next parse state
  always_comb begin : next_state
    acp_pkg::acp_phase_t ph;
    logic [31:0] word;
    logic        done;
    ph           = phase_r;
    biw_nxt      = biw_r;
    wshift_nxt   = wshift_r;
    name_len_nxt = name_len_r;
    brem_nxt     = brem_r;
    stamp_nxt    = stamp_r;
    uid_nxt      = uid_r;
    gid_nxt      = gid_r;
    gcount_nxt   = gcount_r;
    gidx_nxt     = gidx_r;
    status_nxt   = status_r;
    word         = '0;
    done         = 1'b0;

    if (first_byte) begin
      ph           = acp_pkg::PH_STAMP;
      biw_nxt      = '0;
      wshift_nxt   = '0;
      name_len_nxt = '0;
      brem_nxt     = '0;
      stamp_nxt    = '0;
      uid_nxt      = '0;
      gid_nxt      = '0;
      gcount_nxt   = '0;
      gidx_nxt     = '0;
      status_nxt   = acp_pkg::ST_OK;
      if (!sys_flavor) begin
        status_nxt = acp_pkg::ST_NOT_SYS;
        ph         = acp_pkg::PH_END;
      end
    end

    if (has_data) begin
      // Collect big-endian words in every phase except the name and the end.
      if (ph != acp_pkg::PH_NAME && ph != acp_pkg::PH_END) begin
        word = {wshift_nxt, body_byte};
        done = (biw_nxt == 2'd3);
        if (done) begin
          wshift_nxt = '0;
          biw_nxt    = '0;
        end else begin
          wshift_nxt = {wshift_nxt[15:0], body_byte};
          biw_nxt    = biw_nxt + 2'd1;
        end
      end
      case (ph)
        acp_pkg::PH_STAMP: begin
          if (done) begin
            stamp_nxt = word;
            ph        = acp_pkg::PH_NAMELEN;
          end
        end
        acp_pkg::PH_NAMELEN: begin
          if (done) begin
            if (word > {24'd0, max_name}) begin
              status_nxt = acp_pkg::ST_NAME_LONG;
              ph         = acp_pkg::PH_END;
            end else begin
              name_len_nxt = word[7:0];
              brem_nxt     = ({1'b0, word[7:0]} + 9'd3) & 9'h1FC;
              ph           = (word[7:0] == 8'd0) ? acp_pkg::PH_UID : acp_pkg::PH_NAME;
            end
          end
        end
        acp_pkg::PH_NAME: begin
          if (brem_nxt != 9'd0) begin
            brem_nxt = brem_nxt - 9'd1;
          end
          if (brem_nxt == 9'd0) begin
            ph = acp_pkg::PH_UID;
          end
        end
        acp_pkg::PH_UID: begin
          if (done) begin
            uid_nxt = word;
            ph      = acp_pkg::PH_GID;
          end
        end
        acp_pkg::PH_GID: begin
          if (done) begin
            gid_nxt = word;
            ph      = acp_pkg::PH_GCOUNT;
          end
        end
        acp_pkg::PH_GCOUNT: begin
          if (done) begin
            if (word > {27'd0, max_gids}) begin
              status_nxt = acp_pkg::ST_TOO_MANY;
              ph         = acp_pkg::PH_END;
            end else begin
              gcount_nxt = word[4:0];
              gidx_nxt   = '0;
              ph         = (word[4:0] == 5'd0) ? acp_pkg::PH_END : acp_pkg::PH_GIDS;
            end
          end
        end
        acp_pkg::PH_GIDS: begin
          if (done) begin
            gidx_nxt = gidx_nxt + 5'd1;
            if (gidx_nxt >= gcount_nxt) begin
              ph = acp_pkg::PH_END;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (last_byte) begin
      if (ph != acp_pkg::PH_END && status_nxt == acp_pkg::ST_OK) begin
        status_nxt = acp_pkg::ST_TRUNC;
      end
      ph = acp_pkg::PH_END;
    end

    phase_nxt = ph;
  end

  // Queue entry for this request
  always_comb begin : entry_out
    logic [8:0] padded;
    logic [8:0] pos;
    logic       name_hit;
    logic       gid_hit;
    padded   = ({1'b0, name_len_r} + 9'd3) & 9'h1FC;
    pos      = padded - brem_r;
    name_hit = has_data && !first_byte && phase_r == acp_pkg::PH_NAME &&
               pos < {1'b0, name_len_r};
    gid_hit  = has_data && !first_byte && phase_r == acp_pkg::PH_GIDS && biw_r == 2'd3;

    entry.has_item   = name_hit || gid_hit;
    entry.item_kind  = gid_hit ? acp_pkg::KIND_GID : acp_pkg::KIND_NAME;
    entry.item_value = gid_hit ? {wshift_r, body_byte} : {24'd0, body_byte};
    entry.item_index = gid_hit ? {3'd0, gidx_r} : pos[7:0];
    entry.has_sum    = last_byte;
    entry.status     = status_nxt;
    entry.stamp      = stamp_nxt;
    entry.uid        = uid_nxt;
    entry.gid        = gid_nxt;
    entry.name_len   = name_len_nxt;
    entry.gcount     = gcount_nxt;
    push             = accept && (entry.has_item || entry.has_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= acp_pkg::PH_STAMP;
      biw_r      <= '0;
      wshift_r   <= '0;
      name_len_r <= '0;
      brem_r     <= '0;
      stamp_r    <= '0;
      uid_r      <= '0;
      gid_r      <= '0;
      gcount_r   <= '0;
      gidx_r     <= '0;
      status_r   <= acp_pkg::ST_OK;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      biw_r      <= biw_nxt;
      wshift_r   <= wshift_nxt;
      name_len_r <= name_len_nxt;
      brem_r     <= brem_nxt;
      stamp_r    <= stamp_nxt;
      uid_r      <= uid_nxt;
      gid_r      <= gid_nxt;
      gcount_r   <= gcount_nxt;
      gidx_r     <= gidx_nxt;
      status_r   <= status_nxt;
    end
  end

endmodule

FILE: design/acp_queue.sv
// Entry queue between the parser front end and the result back end.
`timescale 1ns / 1ps

module acp_queue #(
  parameter int Depth = acp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  acp_pkg::acp_entry_t wr_entry,
  input  logic                pop,
  output acp_pkg::acp_entry_t head,
  output acp_pkg::acp_q_stat_t stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  acp_pkg::acp_entry_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign stat.full  = (count_r == FullCnt);
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: design/acp_back.sv
// Back end: splits queue entries into results and drives the output register.
`timescale 1ns / 1ps

module acp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  acp_pkg::acp_entry_t  head,
  input  acp_pkg::acp_q_stat_t stat,
  output logic                 pop,
  input  logic                 out_ready,
  output logic                 out_valid,
  output acp_pkg::acp_res_t    out_res
);

  logic              out_valid_r, out_valid_nxt;
  acp_pkg::acp_res_t out_r, out_nxt;
  logic              sub_r, sub_nxt;
  logic              load;

  assign load      = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    sub_nxt       = sub_r;
    pop           = 1'b0;
    if (load && !stat.empty) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      if (head.has_item && !sub_r) begin
        out_nxt.kind       = head.item_kind;
        out_nxt.item_value = head.item_value;
        out_nxt.item_index = head.item_index;
        out_nxt.run_end    = !head.has_sum;
        // Hold the entry for its summary, or drop it now.
        if (head.has_sum) begin
          sub_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        out_nxt.kind     = acp_pkg::KIND_SUM;
        out_nxt.status   = head.status;
        out_nxt.stamp    = head.stamp;
        out_nxt.uid      = head.uid;
        out_nxt.gid      = head.gid;
        out_nxt.name_len = head.name_len;
        out_nxt.gcount   = head.gcount;
        out_nxt.run_end  = 1'b1;
        sub_nxt          = 1'b0;
        pop              = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
    end
  end

endmodule

FILE: design/auth_sys_credential_parser.sv
// Top level of the system-flavor credential parser: channels, registers, front and back.
//
// Usage: in_chan carries one credential body byte per request with has_data,
// first_byte, last_byte and sys_flavor marks. out_chan carries results: a
// machine-name byte, a group id, or the summary given on the request marked
// last_byte. Both are valid/ready channels; a request is taken on valid && ready.
// The APB port writes max_name_length (address 0) and max_group_count (4).
// A result passes through the entry queue and then the output register before it
// appears on out_chan. Throughput: one request per cycle while the queue is not full;
// a request that yields both a list result and the summary gives them one after the
// other from the single output register, which drains the entry queue.
// Reset (synchronous, rst_n low) starts a fresh system-flavor parse, empties the
// queue and loads the register defaults 255 and 16.
// A stalled receiver holds the output register; the queue keeps taking
// requests until QueueDepth entries wait, then in_chan.ready drops.
`timescale 1ns / 1ps

module auth_sys_credential_parser #(
  parameter int QueueDepth = acp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  acp_in_if.sink      in_chan,
  acp_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]           max_name_r, max_name_nxt;
  logic [4:0]           max_gids_r, max_gids_nxt;
  logic                 cfg_wr;
  logic                 accept;
  logic                 push;
  logic                 pop;
  acp_pkg::acp_entry_t  entry;
  acp_pkg::acp_entry_t  head;
  acp_pkg::acp_q_stat_t stat;
  acp_pkg::acp_res_t    res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    max_name_nxt = max_name_r;
    max_gids_nxt = max_gids_r;
    if (cfg_wr) begin
      case ({paddr[2], 2'b00})
        acp_pkg::REG_NAME_MAX: max_name_nxt = pwdata[7:0];
        acp_pkg::REG_GIDS_MAX: max_gids_nxt = pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case ({paddr[2], 2'b00})
      acp_pkg::REG_NAME_MAX: prdata = {24'd0, max_name_r};
      acp_pkg::REG_GIDS_MAX: prdata = {27'd0, max_gids_r};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_name_r <= acp_pkg::NAME_MAX_RST;
      max_gids_r <= acp_pkg::GIDS_MAX_RST;
    end else begin
      max_name_r <= max_name_nxt;
      max_gids_r <= max_gids_nxt;
    end
  end

  assign in_chan.ready = !stat.full;
  assign accept        = in_chan.valid && !stat.full;

  acp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .body_byte  (in_chan.body_byte),
    .has_data   (in_chan.has_data),
    .first_byte (in_chan.first_byte),
    .last_byte  (in_chan.last_byte),
    .sys_flavor (in_chan.sys_flavor),
    .max_name   (max_name_r),
    .max_gids   (max_gids_r),
    .push       (push),
    .entry      (entry)
  );

  acp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  acp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_res   (res)
  );

  assign out_chan.kind            = res.kind;
  assign out_chan.item_value      = res.item_value;
  assign out_chan.item_index      = res.item_index;
  assign out_chan.status          = res.status;
  assign out_chan.stamp_out       = res.stamp;
  assign out_chan.uid_out         = res.uid;
  assign out_chan.gid_out         = res.gid;
  assign out_chan.name_length_out = res.name_len;
  assign out_chan.group_count_out = res.gcount;
  assign out_chan.run_end         = res.run_end;

endmodule

FILE: design/acp_checker.sv
// Port checker for the credential parser result channel, with its bind.
`timescale 1ns / 1ps
`include "auth_sys_credential_parser_assert.svh"

module acp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [31:0] item_value,
  input logic [2:0]  status,
  input logic [31:0] stamp_out,
  input logic [31:0] uid_out,
  input logic        run_end
);

  `ACP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(item_value) && $stable(run_end), "stalled result changed")
  `ACP_ASSERT_NOW(a_sum_ends_run, out_valid && kind == acp_pkg::KIND_SUM, run_end, "summary without run_end")
  `ACP_ASSERT_NOW(a_item_clean, out_valid && kind != acp_pkg::KIND_SUM, status == acp_pkg::ST_OK && stamp_out == 32'd0 && uid_out == 32'd0, "list result carries summary fields")
  `ACP_ASSERT_NOW(a_reset_idle, !$past(rst_n), !out_valid, "result valid right after reset")

endmodule

bind auth_sys_credential_parser acp_checker u_acp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .kind       (out_chan.kind),
  .item_value (out_chan.item_value),
  .status     (out_chan.status),
  .stamp_out  (out_chan.stamp_out),
  .uid_out    (out_chan.uid_out),
  .run_end    (out_chan.run_end)
);
